>>> hdl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and codes for the sorted ID set with checked marks.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int ID_W         = 32;
  localparam int CMD_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int ENTRY_W      = 9;

  localparam logic [CMD_W-1:0] CMD_MARK_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_UNREAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PURGE       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESET_MARKS = 3'd4;

  localparam logic [STATUS_W-1:0] ST_CHANGED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_SETMARK,
    CELL_CLRMARK,
    CELL_PURGE_INIT,
    CELL_SWEEP
  } cell_op_e;

  typedef struct packed {
    cell_op_e        op;
    logic [ID_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            mark;
    logic            valid;
    logic            lt;
  } cell_data_t;

endpackage

>>> hdl/sorted_id_set_with_marks_top.sv
// Insert, remove, check, reset marks and unused codes: the result is registered
// after the compare step; a new request is taken only once the block is idle again.
// Purge unchecked: drops unmarked entries, packs the rest with the odd-even sweep.
// The result sits in an output register, with one pending slot behind it.
// rst_ni clears all cells, count and flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_id_set_with_marks_top
// Ascending set of IDs with checked marks, held in a chain of compare cells.
// ----------------------------------------------------------------------------
module sorted_id_set_with_marks_top #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sis_pkg::CMD_W-1:0]     command_i,
  input  logic [sis_pkg::ID_W-1:0]      item_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          was_present_o,
  output logic [sis_pkg::STATUS_W-1:0]  status_o,
  output logic [sis_pkg::ENTRY_W-1:0]   entry_count_o,
  output logic                          modified_o
);
  import sis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [ID_W-1:0]     key_q, key_d;
  logic [CW-1:0]       count_q, count_d;
  logic                mod_q, mod_d;
  logic [SW-1:0]       sweep_q, sweep_d;

  cell_ctl_t           ctl;
  cell_data_t          cells [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] lower_vec;
  logic [CAPACITY-1:0] tail_vec;
  logic [CW-1:0]       packed_count;

  logic                fin;
  logic                r_present;
  logic [STATUS_W-1:0] r_status;
  logic                load_out, load_res, load_from_res;

  logic                out_valid_q;
  logic                out_present_q, res_present_q;
  logic [STATUS_W-1:0] out_status_q, res_status_q;
  logic [CW-1:0]       out_count_q, res_count_q;
  logic                out_mod_q, res_mod_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_data_t left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '{id: '0, mark: 1'b0, valid: 1'b1, lt: 1'b1};
    end else begin : g_mid_l
      assign left_d = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '{id: '0, mark: 1'b0, valid: 1'b0, lt: 1'b0};
    end else begin : g_mid_r
      assign right_d = cells[i+1];
    end
    assign lower_vec[i] = (sweep_q[0] == 1'(i % 2));
    assign valid_vec[i] = cells[i].valid;

    sis_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .lower_i (lower_vec[i]),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cells[i]),
      .eq_o    (eq_vec[i])
    );
  end

  // after compaction the held entries form a prefix; its end gives the count
  assign tail_vec = valid_vec & ~(valid_vec >> 1);

  always_comb begin
    packed_count = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_vec[i]) packed_count = packed_count | CW'(i + 1);
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    count_d   = count_q;
    mod_d     = mod_q;
    sweep_d   = sweep_q;
    ctl.op    = CELL_HOLD;
    ctl.key   = key_q;
    fin       = 1'b0;
    r_present = 1'b0;
    r_status  = ST_UNCHANGED;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl.op  = CELL_CMP;
          ctl.key = item_id_i;
          cmd_d   = command_i;
          key_d   = item_id_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        fin = 1'b1;
        unique case (cmd_q)
          CMD_MARK_READ: begin
            r_present = |eq_vec;
            if (!r_present) begin
              if (count_q == CW'(CAPACITY)) begin
                r_status = ST_FULL;
              end else begin
                ctl.op   = CELL_INS;
                count_d  = count_q + 1'b1;
                mod_d    = 1'b1;
                r_status = ST_CHANGED;
              end
            end
          end
          CMD_MARK_UNREAD: begin
            r_present = |eq_vec;
            if (r_present) begin
              ctl.op   = CELL_DEL;
              count_d  = count_q - 1'b1;
              mod_d    = 1'b1;
              r_status = ST_CHANGED;
            end
          end
          CMD_CHECK: begin
            r_present = |eq_vec;
            ctl.op    = CELL_SETMARK;
          end
          CMD_PURGE: begin
            fin     = 1'b0;
            ctl.op  = CELL_PURGE_INIT;
            sweep_d = '0;
            state_d = S_SWEEP;
          end
          CMD_RESET_MARKS: begin
            ctl.op = CELL_CLRMARK;
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        ctl.op  = CELL_SWEEP;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == SW'(CAPACITY - 1)) state_d = S_COUNT;
      end
      S_COUNT: begin
        fin     = 1'b1;
        count_d = packed_count;
        if (packed_count != count_q) begin
          mod_d    = 1'b1;
          r_status = ST_CHANGED;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      else state_d = S_HOLD;
    end
  end

  assign load_out      = fin && (!out_valid_q || out_ready_i);
  assign load_res      = fin && out_valid_q && !out_ready_i;
  assign load_from_res = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mod_q       <= 1'b0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mod_q   <= mod_d;
      sweep_q <= sweep_d;
      if (load_out || load_from_res) out_valid_q <= 1'b1;
      else if (out_ready_i)          out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    if (load_res) begin
      res_present_q <= r_present;
      res_status_q  <= r_status;
      res_count_q   <= count_d;
      res_mod_q     <= mod_d;
    end
    if (load_out) begin
      out_present_q <= r_present;
      out_status_q  <= r_status;
      out_count_q   <= count_d;
      out_mod_q     <= mod_d;
    end else if (load_from_res) begin
      out_present_q <= res_present_q;
      out_status_q  <= res_status_q;
      out_count_q   <= res_count_q;
      out_mod_q     <= res_mod_q;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign was_present_o = out_present_q;
  assign status_o      = out_status_q;
  assign entry_count_o = ENTRY_W'(out_count_q);
  assign modified_o    = out_mod_q;

endmodule

>>> hdl/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell
// One slot of the sorted chain: holds an ID, its mark and occupancy, compares
// against the broadcast key and shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module sis_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sis_pkg::cell_ctl_t  ctl_i,
  input  logic                lower_i,
  input  sis_pkg::cell_data_t left_i,
  input  sis_pkg::cell_data_t right_i,
  output sis_pkg::cell_data_t data_o,
  output logic                eq_o
);
  import sis_pkg::*;

  logic [ID_W-1:0] id_q, id_d;
  logic            mark_q, mark_d;
  logic            valid_q, valid_d;
  logic            lt_q, lt_d;
  logic            eq_q, eq_d;

  always_comb begin
    id_d    = id_q;
    mark_d  = mark_q;
    valid_d = valid_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_CMP: begin
        lt_d = valid_q && (id_q < ctl_i.key);
        eq_d = valid_q && (id_q == ctl_i.key);
      end
      CELL_INS: begin
        if (!lt_q) begin
          if (left_i.lt) begin
            id_d    = ctl_i.key;
            mark_d  = 1'b1;
            valid_d = 1'b1;
          end else begin
            id_d    = left_i.id;
            mark_d  = left_i.mark;
            valid_d = left_i.valid;
          end
        end
      end
      CELL_DEL: begin
        if (!lt_q) begin
          id_d    = right_i.id;
          mark_d  = right_i.mark;
          valid_d = right_i.valid;
        end
      end
      CELL_SETMARK: begin
        if (eq_q) mark_d = 1'b1;
      end
      CELL_CLRMARK: begin
        mark_d = 1'b0;
      end
      CELL_PURGE_INIT: begin
        valid_d = valid_q & mark_q;
        mark_d  = 1'b0;
      end
      CELL_SWEEP: begin
        // odd-even exchange: holes drift up, survivors drift down in order
        if (lower_i) begin
          if (!valid_q && right_i.valid) begin
            id_d    = right_i.id;
            valid_d = 1'b1;
          end
        end else begin
          if (!left_i.valid && valid_q) valid_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q  <= 1'b0;
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      mark_q  <= mark_d;
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign data_o.id    = id_q;
  assign data_o.mark  = mark_q;
  assign data_o.valid = valid_q;
  assign data_o.lt    = lt_q;
  assign eq_o         = eq_q;

endmodule

>>> bench/tb_sorted_id_set_with_marks_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_id_set_with_marks_top
// Drives insert, remove, check, purge, mark-clear and unused-code requests into the sorted
// ID set. A software copy of the set predicts every result, and each result
// is checked field by field in order. The run covers directed corner cases,
// filling the store to capacity under a long output stall, and a random mix.
// ----------------------------------------------------------------------------
module tb_sorted_id_set_with_marks_top;
  import sis_pkg::*;

  localparam int SET_CAPACITY = CAPACITY_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_ITEMS  = 120;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic                was_present;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_count;
    logic                modified;
  } set_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i     = CMD_MARK_READ;
  logic [ID_W-1:0]     item_id_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                was_present_o;
  logic [STATUS_W-1:0] status_o;
  logic [ENTRY_W-1:0]  entry_count_o;
  logic                modified_o;

  // Shadow copy of the set
  logic [ID_W-1:0] held_ids   [SET_CAPACITY];
  logic            held_marks [SET_CAPACITY];
  int              held_total = 0;
  logic            set_dirty  = 1'b0;

  set_result_t pending_results [$];
  set_result_t got_result;
  set_result_t want_result;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_len       = 0;
  bit quiet_stretch  = 1'b0;

  sorted_id_set_with_marks_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .item_id_i     (item_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .was_present_o (was_present_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .modified_o    (modified_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic set_result_t apply_request(input logic [CMD_W-1:0] cmd,
                                                input logic [ID_W-1:0] id);
    set_result_t res;
    int          pos;
    int          kept;
    logic        found;
    res.was_present = 1'b0;
    res.status      = ST_UNCHANGED;
    pos             = 0;
    found           = 1'b0;
    if (cmd == CMD_MARK_READ || cmd == CMD_MARK_UNREAD || cmd == CMD_CHECK) begin
      while (pos < held_total && held_ids[pos] < id) pos++;
      found = (pos < held_total) && (held_ids[pos] == id);
    end
    case (cmd)
      CMD_MARK_READ: begin
        if (!found) begin
          if (held_total >= SET_CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (int i = held_total; i > pos; i--) begin
              held_ids[i]   = held_ids[i-1];
              held_marks[i] = held_marks[i-1];
            end
            held_ids[pos]   = id;
            held_marks[pos] = 1'b1;
            held_total++;
            set_dirty  = 1'b1;
            res.status = ST_CHANGED;
          end
        end
      end
      CMD_MARK_UNREAD: begin
        if (found) begin
          for (int i = pos; i < held_total - 1; i++) begin
            held_ids[i]   = held_ids[i+1];
            held_marks[i] = held_marks[i+1];
          end
          held_total--;
          set_dirty  = 1'b1;
          res.status = ST_CHANGED;
        end
      end
      CMD_CHECK: begin
        if (found) held_marks[pos] = 1'b1;
      end
      CMD_PURGE: begin
        kept = 0;
        for (int i = 0; i < held_total; i++) begin
          if (held_marks[i]) begin
            held_ids[kept] = held_ids[i];
            kept++;
          end
        end
        if (kept != held_total) begin
          held_total = kept;
          set_dirty  = 1'b1;
          res.status = ST_CHANGED;
        end
        for (int i = 0; i < SET_CAPACITY; i++) held_marks[i] = 1'b0;
      end
      CMD_RESET_MARKS: begin
        for (int i = 0; i < SET_CAPACITY; i++) held_marks[i] = 1'b0;
      end
      default: begin
      end
    endcase
    res.was_present = found;
    res.entry_count = held_total[ENTRY_W-1:0];
    res.modified    = set_dirty;
    return res;
  endfunction

  // Mostly held IDs and a narrow band of small values, so hits are common
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && held_total > 0) return held_ids[$urandom_range(0, held_total - 1)];
    if (roll < 75) return ID_W'($urandom_range(0, 63));
    if (roll < 80) return '1 - ID_W'($urandom_range(0, 7));
    return $urandom();
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    while (!quiet_stretch && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    item_id_i  <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_request(cmd, id));
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(CMD_CHECK, '0);
    send_request(CMD_MARK_UNREAD, '0);
    send_request(CMD_MARK_READ, 32'h8000_0000);
    send_request(CMD_MARK_READ, '0);
    send_request(CMD_MARK_READ, '1);
    send_request(CMD_MARK_READ, '0);
    send_request(CMD_CHECK, 32'h8000_0000);
    send_request(CMD_CHECK, 32'h0000_1234);
    send_request(CMD_RESET_MARKS, 32'hDEAD_BEEF);
    send_request(CMD_CHECK, '0);
    send_request(CMD_PURGE, '1);
    send_request(CMD_PURGE, '0);
    send_request(CMD_MARK_READ, 32'h7FFF_FFFF);
    send_request(CMD_MARK_READ, 32'h0000_0001);
    send_request(CMD_MARK_UNREAD, 32'h0000_0005);
    send_request(CMD_MARK_UNREAD, '0);
    send_request(CMD_SPARE_FIRST, '1);
    send_request(CMD_SPARE_FIRST + 3'd1, '0);
    send_request(CMD_SPARE_LAST, 32'h0000_0001);
    send_request(CMD_RESET_MARKS, '0);
    send_request(CMD_PURGE, 32'hA5A5_5A5A);
  endtask

  // Receiver holds off while the store fills, so the input backs up
  task automatic test_fill_and_stall();
    hold_len = HOLD_CYCLES;
    while (held_total < SET_CAPACITY) send_request(CMD_MARK_READ, $urandom());
    send_request(CMD_MARK_READ, $urandom());
    send_request(CMD_MARK_READ, held_ids[SET_CAPACITY/2]);
    send_request(CMD_MARK_UNREAD, held_ids[0]);
    send_request(CMD_MARK_READ, '1);
    send_request(CMD_MARK_READ, $urandom());
    send_request(CMD_RESET_MARKS, $urandom());
    repeat (64) send_request(CMD_CHECK, held_ids[$urandom_range(0, held_total - 1)]);
    send_request(CMD_CHECK, $urandom());
    send_request(CMD_PURGE, $urandom());
    repeat (8) send_request(CMD_MARK_UNREAD, pick_id());
  endtask

  task automatic test_random_mix(input int num_items);
    int unsigned roll;
    for (int n = 0; n < num_items; n++) begin
      quiet_stretch = (n < QUIET_ITEMS);
      roll = $urandom_range(0, 99);
      if (roll < 34)      send_request(CMD_MARK_READ, pick_id());
      else if (roll < 52) send_request(CMD_MARK_UNREAD, pick_id());
      else if (roll < 80) send_request(CMD_CHECK, pick_id());
      else if (roll < 84) send_request(CMD_PURGE, $urandom());
      else if (roll < 89) send_request(CMD_RESET_MARKS, $urandom());
      else if (roll < 91) send_request(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                                       $urandom());
      else                send_request(CMD_MARK_READ, $urandom());
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      out_ready_i <= quiet_stretch || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_result = '{was_present_o, status_o, entry_count_o, modified_o};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: present=%0d status=%0d count=%0d modified=%0d",
                   got_result.was_present, got_result.status,
                   got_result.entry_count, got_result.modified);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.was_present !== want_result.was_present ||
            got_result.status      !== want_result.status ||
            got_result.entry_count !== want_result.entry_count ||
            got_result.modified    !== want_result.modified) begin
          if (mismatch_count < 10)
            $display("mismatch: present %0d/%0d status %0d/%0d count %0d/%0d modified %0d/%0d",
                     want_result.was_present, got_result.was_present,
                     want_result.status, got_result.status,
                     want_result.entry_count, got_result.entry_count,
                     want_result.modified, got_result.modified);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < SET_CAPACITY; i++) begin
      held_ids[i]   = '0;
      held_marks[i] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_directed();
    pause_until_drained();
    test_fill_and_stall();
    pause_until_drained();
    test_random_mix(400);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SET_CAPACITY + 8) @(posedge clk_i);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
